/* sv/inter_arrival_histogram_defines.svh */
// Assertion macros shared by the histogram checker.
`ifndef INTER_ARRIVAL_HISTOGRAM_DEFINES_SVH
`define INTER_ARRIVAL_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IAH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IAH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/iah_pkg.sv */
// Shared types and codes of the inter-arrival histogram.
package iah_pkg;

  localparam logic [1:0] ACT_EVENT  = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam logic       REG_BIN_WIDTH   = 1'b0;
  localparam logic [31:0] BIN_WIDTH_RESET = 32'd100;

  localparam int DIV_STEPS = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_FETCH,
    ST_INCR,
    ST_PEEK,
    ST_REPLY
  } iah_state_t;

endpackage

/* sv/inter_arrival_histogram.sv */
// Inter-arrival time histogram: gap divider and bin counters in one RAM.
// Event: the gap runs through 32 divider steps, a RAM read (FETCH) and a write (INCR); busy until the result.
// Bin read: RAM read in PEEK, result in REPLY; baseline, unused, out-of-range read: result registered on accept.
// Clear: one RAM entry zeroed per cycle over all NUM_BINS entries; busy is high throughout.
// Reset runs the same clearing pass (no result); config writes still land.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
module inter_arrival_histogram #(
  parameter int NUM_BINS = 100
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_timestamp_ms,
  input  logic [6:0]  in_read_bin,
  output logic        out_valid,
  output logic [6:0]  out_bin_index,
  output logic [31:0] out_hit_count,
  output logic        out_baseline_only,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import iah_pkg::*;

  localparam int IW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [IW-1:0] LAST_BIN = IW'(NUM_BINS - 1);

  iah_state_t state_r, state_nxt;

  logic [31:0]   bin_width_r;
  logic [31:0]   prev_ts_r, prev_ts_nxt;
  logic          base_valid_r, base_valid_nxt;
  logic          report_r, report_nxt;
  logic [IW-1:0] ptr_r, ptr_nxt;
  logic [IW-1:0] addr_r, addr_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   quot_r, quot_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    out_idx_r, out_idx_nxt;
  logic [31:0]   out_cnt_r, out_cnt_nxt;
  logic          out_base_r, out_base_nxt;

  logic [31:0]   mem [NUM_BINS];
  logic [31:0]   rd_data_r;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  logic          accept;
  logic          rb_in_range;
  logic [31:0]   rb_ext;
  logic [31:0]   addr_ext;
  logic [32:0]   rem_sh;
  logic [32:0]   diff;
  logic          ge;
  logic [31:0]   quot_step;
  logic          cfg_wr;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r != ST_IDLE);
  assign rb_ext      = 32'(in_read_bin);
  assign rb_in_range = (rb_ext < 32'(NUM_BINS));
  assign addr_ext    = 32'(addr_r);

  // One restoring divider step: remainder stays below the divisor.
  assign rem_sh    = {rem_r, quot_r[31]};
  assign diff      = rem_sh - {1'b0, bin_width_r};
  assign ge        = !diff[32];
  assign quot_step = {quot_r[30:0], ge};

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BIN_WIDTH) ? bin_width_r : 32'd0;

  assign out_valid         = out_valid_r;
  assign out_bin_index     = out_idx_r;
  assign out_hit_count     = out_cnt_r;
  assign out_baseline_only = out_base_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_EVENT: state_nxt = base_valid_r ? ST_DIV : ST_IDLE;
            ACT_CLEAR: state_nxt = ST_CLEAR;
            ACT_READ:  state_nxt = rb_in_range ? ST_PEEK : ST_IDLE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: if (ptr_r == LAST_BIN) state_nxt = ST_IDLE;
      ST_DIV:   if (cnt_r == 5'd0) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_INCR;
      ST_INCR:  state_nxt = ST_IDLE;
      ST_PEEK:  state_nxt = ST_REPLY;
      ST_REPLY: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    prev_ts_nxt    = prev_ts_r;
    base_valid_nxt = base_valid_r;
    report_nxt     = report_r;
    ptr_nxt        = ptr_r;
    addr_nxt       = addr_r;
    rem_nxt        = rem_r;
    quot_nxt       = quot_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_cnt_nxt    = out_cnt_r;
    out_base_nxt   = out_base_r;
    mem_we         = 1'b0;
    mem_waddr      = addr_r;
    mem_wdata      = rd_data_r + 32'd1;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_idx_nxt  = 7'd0;
          out_cnt_nxt  = 32'd0;
          out_base_nxt = 1'b0;
          case (in_action)
            ACT_EVENT: begin
              prev_ts_nxt = in_timestamp_ms;
              if (base_valid_r) begin
                rem_nxt  = 32'd0;
                quot_nxt = in_timestamp_ms - prev_ts_r;
                cnt_nxt  = 5'(DIV_STEPS - 1);
              end else begin
                base_valid_nxt = 1'b1;
                out_base_nxt   = 1'b1;
                out_valid_nxt  = 1'b1;
              end
            end
            ACT_CLEAR: begin
              base_valid_nxt = 1'b0;
              prev_ts_nxt    = 32'd0;
              report_nxt     = 1'b1;
              ptr_nxt        = '0;
            end
            ACT_READ: begin
              out_idx_nxt = in_read_bin;
              addr_nxt    = rb_ext[IW-1:0];
              if (!rb_in_range) out_valid_nxt = 1'b1;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = 32'd0;
        ptr_nxt   = ptr_r + IW'(1);
        if (ptr_r == LAST_BIN) begin
          out_valid_nxt = report_r;
          report_nxt    = 1'b0;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? diff[31:0] : rem_sh[31:0];
        quot_nxt = quot_step;
        cnt_nxt  = cnt_r - 5'd1;
        // saturate into the tail bin
        if (cnt_r == 5'd0) begin
          addr_nxt = (quot_step >= 32'(NUM_BINS - 1)) ? LAST_BIN : quot_step[IW-1:0];
        end
      end
      ST_INCR: begin
        mem_we        = 1'b1;
        out_valid_nxt = 1'b1;
        out_idx_nxt   = addr_ext[6:0];
        out_cnt_nxt   = rd_data_r + 32'd1;
      end
      ST_REPLY: begin
        out_valid_nxt = 1'b1;
        out_cnt_nxt   = rd_data_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      prev_ts_r    <= 32'd0;
      base_valid_r <= 1'b0;
      report_r     <= 1'b0;
      ptr_r        <= '0;
      out_valid_r  <= 1'b0;
      bin_width_r  <= BIN_WIDTH_RESET;
    end else begin
      state_r      <= state_nxt;
      prev_ts_r    <= prev_ts_nxt;
      base_valid_r <= base_valid_nxt;
      report_r     <= report_nxt;
      ptr_r        <= ptr_nxt;
      out_valid_r  <= out_valid_nxt;
      // drop zero widths
      if (cfg_wr && (paddr[2] == REG_BIN_WIDTH) && (pwdata != 32'd0)) begin
        bin_width_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    rem_r      <= rem_nxt;
    quot_r     <= quot_nxt;
    cnt_r      <= cnt_nxt;
    out_idx_r  <= out_idx_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_base_r <= out_base_nxt;
  end

endmodule

/* sv/iah_checker.sv */
// Port-level checker of the inter-arrival histogram, bound to the top level.
`include "inter_arrival_histogram_defines.svh"

module iah_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic [6:0]  out_bin_index,
  input logic [31:0] out_hit_count,
  input logic        out_baseline_only
);
  import iah_pkg::*;

  logic clear_req;
  logic unused_req;
  logic empty_res;
  logic base_res;

  assign clear_req  = start && !busy && (in_action == ACT_CLEAR);
  assign unused_req = start && !busy && (in_action == ACT_UNUSED);
  assign empty_res  = (out_bin_index == 7'd0) && (out_hit_count == 32'd0);
  assign base_res   = out_valid && out_baseline_only;

  `IAH_ASSERT_NEXT(a_clear_holds_busy, clear_req, busy, "clear request left busy low")
  `IAH_ASSERT_NEXT(a_unused_action_reply, unused_req, out_valid && empty_res, "bad unused result")
  `IAH_ASSERT_SAME(a_baseline_empty, base_res, empty_res, "baseline result carries a bin")
  `IAH_ASSERT_SAME(a_result_when_idle, out_valid, !busy, "result strobed while still busy")

endmodule

bind inter_arrival_histogram iah_port_checks u_iah_checker (.*);
